// File: rtl/core/llsa_pkg.sv
package llsa_pkg;

    localparam int MAX_SERVERS_DEF = 16;
    localparam int NS_W            = 5;
    localparam int SRV_W           = 5;
    localparam int LOAD_W          = 32;
    localparam int JOB_W           = 16;

    localparam logic [NS_W-1:0]   NUM_SERVERS_RST = NS_W'(16);
    localparam logic [LOAD_W-1:0] LOAD_MAX        = {LOAD_W{1'b1}};

    localparam logic CMD_CLEAR = 1'b0;
    localparam logic CMD_JOB   = 1'b1;

    typedef struct packed {
        logic capture;
        logic clear_all;
        logic scan_start;
        logic update;
        logic publish;
    } dp_cmd_t;

    typedef struct packed {
        logic search_idle;
        logic cache_valid;
    } dp_status_t;

endpackage

// File: rtl/core/llsa_ctrl.sv
module llsa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                cmd,
    output logic                out_valid,
    input  logic                out_ready,
    output llsa_pkg::dp_cmd_t   dp_cmd,
    input  llsa_pkg::dp_status_t dp_status
);
    import llsa_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_A,
        ST_UPDATE,
        ST_SCAN_B,
        ST_PUBLISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        dp_cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    dp_cmd.capture = 1'b1;
                    if (cmd == CMD_CLEAR)
                    begin
                        dp_cmd.clear_all = 1'b1;
                        state_next       = ST_PUBLISH;
                    end
                    else if (dp_status.cache_valid)
                    begin
                        state_next = ST_UPDATE;
                    end
                    else
                    begin
                        dp_cmd.scan_start = 1'b1;
                        state_next        = ST_SCAN_A;
                    end
                end
            end
            ST_SCAN_A:
            begin
                if (dp_status.search_idle)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                dp_cmd.update     = 1'b1;
                dp_cmd.scan_start = 1'b1;
                state_next        = ST_SCAN_B;
            end
            ST_SCAN_B:
            begin
                if (dp_status.search_idle)
                begin
                    state_next = ST_PUBLISH;
                end
            end
            ST_PUBLISH:
            begin
                if (out_free)
                begin
                    dp_cmd.publish = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/core/llsa_dp.sv
module llsa_dp #(
    parameter int MAX_SERVERS = llsa_pkg::MAX_SERVERS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [llsa_pkg::NS_W-1:0]    cfg_data,
    input  logic [llsa_pkg::JOB_W-1:0]   job_time,
    input  llsa_pkg::dp_cmd_t            dp_cmd,
    output llsa_pkg::dp_status_t         dp_status,
    output logic [llsa_pkg::SRV_W-1:0]   assigned_server,
    output logic [llsa_pkg::SRV_W-1:0]   next_server,
    output logic                         saturated
);
    import llsa_pkg::*;

    localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int CNT_W = $clog2(MAX_SERVERS + 1);
    localparam int CMP_W = (CNT_W > NS_W) ? CNT_W : NS_W;

    logic [LOAD_W-1:0] load_mem [MAX_SERVERS];
    logic [MAX_SERVERS-1:0] valid_reg;

    logic [NS_W-1:0]   num_servers_reg;
    logic              cache_valid_reg;
    logic              scan_busy_reg;
    logic              cmp_pending_reg;
    logic              first_reg;
    logic [IDX_W-1:0]  scan_addr_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic [LOAD_W-1:0] rd_data_reg;
    logic              rd_vld_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [LOAD_W-1:0] best_load_reg;
    logic [JOB_W-1:0]  job_reg;
    logic [SRV_W-1:0]  asg_reg;
    logic              sat_reg;
    logic [SRV_W-1:0]  out_asg_reg;
    logic [SRV_W-1:0]  out_next_reg;
    logic              out_sat_reg;

    logic [CMP_W-1:0]  ns_ext;
    logic [CMP_W-1:0]  last_ext;
    logic [IDX_W-1:0]  last_idx;
    logic [LOAD_W-1:0] read_load;
    logic              take;
    logic [LOAD_W:0]   sum;
    logic [IDX_W:0]    best_num;

    assign ns_ext = CMP_W'(num_servers_reg);

    always_comb
    begin
        if (ns_ext == '0)
        begin
            last_ext = '0;
        end
        else if (ns_ext > CMP_W'(MAX_SERVERS))
        begin
            last_ext = CMP_W'(MAX_SERVERS - 1);
        end
        else
        begin
            last_ext = ns_ext - CMP_W'(1);
        end
    end

    assign last_idx  = last_ext[IDX_W-1:0];
    assign read_load = rd_vld_reg ? rd_data_reg : '0;
    assign take      = cmp_pending_reg && (first_reg || (read_load < best_load_reg));
    assign sum       = {1'b0, best_load_reg} + (LOAD_W+1)'(job_reg);
    assign best_num  = {1'b0, best_idx_reg} + (IDX_W+1)'(1);

    assign dp_status.search_idle = !scan_busy_reg && !cmp_pending_reg;
    assign dp_status.cache_valid = cache_valid_reg;

    assign assigned_server = out_asg_reg;
    assign next_server     = out_next_reg;
    assign saturated       = out_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_servers_reg <= NUM_SERVERS_RST;
            cache_valid_reg <= 1'b0;
            scan_busy_reg   <= 1'b0;
            cmp_pending_reg <= 1'b0;
            first_reg       <= 1'b0;
            scan_addr_reg   <= '0;
            valid_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                num_servers_reg <= cfg_data;
            end

            if (cfg_we)
            begin
                cache_valid_reg <= 1'b0;
            end
            else if (dp_cmd.clear_all || (cmp_pending_reg && !scan_busy_reg))
            begin
                cache_valid_reg <= 1'b1;
            end

            if (dp_cmd.clear_all)
            begin
                valid_reg <= '0;
            end
            else if (dp_cmd.update)
            begin
                valid_reg[best_idx_reg] <= 1'b1;
            end

            cmp_pending_reg <= scan_busy_reg;
            if (dp_cmd.scan_start)
            begin
                scan_busy_reg <= 1'b1;
                scan_addr_reg <= '0;
                first_reg     <= 1'b1;
            end
            else
            begin
                if (scan_busy_reg)
                begin
                    scan_addr_reg <= scan_addr_reg + IDX_W'(1);
                    if (scan_addr_reg == last_idx)
                    begin
                        scan_busy_reg <= 1'b0;
                    end
                end
                if (cmp_pending_reg)
                begin
                    first_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= load_mem[scan_addr_reg];
        rd_vld_reg  <= valid_reg[scan_addr_reg];
        cmp_idx_reg <= scan_addr_reg;

        if (dp_cmd.update)
        begin
            load_mem[best_idx_reg] <= sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];
        end

        if (dp_cmd.capture)
        begin
            job_reg <= job_time;
        end

        if (dp_cmd.clear_all)
        begin
            best_idx_reg  <= '0;
            best_load_reg <= '0;
            asg_reg       <= '0;
            sat_reg       <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                best_idx_reg  <= cmp_idx_reg;
                best_load_reg <= read_load;
            end
            if (dp_cmd.update)
            begin
                asg_reg <= SRV_W'(best_num);
                sat_reg <= sum[LOAD_W];
            end
        end

        if (dp_cmd.publish)
        begin
            out_asg_reg  <= asg_reg;
            out_next_reg <= SRV_W'(best_num);
            out_sat_reg  <= sat_reg;
        end
    end

endmodule

// File: rtl/core/least_loaded_server_assign_unit.sv
// Channel   Signals                                         Direction
// request   in_valid, in_ready, cmd, job_time               in
// result    out_valid, out_ready, assigned_server,
//           next_server, saturated                          out
// config    cfg_valid, cfg_ready, cfg_data (num_servers)    in
//
// A clear request skips the search and is published when the output is free.
// A job request runs the one-entry-per-cycle minimum search over the loads
// of the active servers in the load memory; a job that follows reset or a
// configuration write first runs an extra search to fill the cached minimum.
// Reset clears all loads through per-server valid bits, with no clearing pass.
// A result waits in its output register while the next request is worked on.
module least_loaded_server_assign_unit #(
    parameter int MAX_SERVERS = llsa_pkg::MAX_SERVERS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [llsa_pkg::NS_W-1:0]    cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         cmd,
    input  logic [llsa_pkg::JOB_W-1:0]   job_time,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [llsa_pkg::SRV_W-1:0]   assigned_server,
    output logic [llsa_pkg::SRV_W-1:0]   next_server,
    output logic                         saturated
);
    import llsa_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    llsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status)
    );

    llsa_dp #(
        .MAX_SERVERS (MAX_SERVERS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_data        (cfg_data),
        .job_time        (job_time),
        .dp_cmd          (dp_cmd),
        .dp_status       (dp_status),
        .assigned_server (assigned_server),
        .next_server     (next_server),
        .saturated       (saturated)
    );

endmodule

// File: rtl/core/llsa_checker.sv
module llsa_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [llsa_pkg::SRV_W-1:0]   assigned_server,
    input logic [llsa_pkg::SRV_W-1:0]   next_server,
    input logic                         saturated
);
    import llsa_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(assigned_server)
            && $stable(next_server) && $stable(saturated))
        else $error("Result changed while stalled.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Request accepted while a request is in progress.");

    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && assigned_server == '0 |-> !saturated && next_server == SRV_W'(1))
        else $error("Clear result is malformed.");

    a_next_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> next_server != '0)
        else $error("Next server is zero.");

endmodule

bind least_loaded_server_assign_unit llsa_checker u_llsa_checker (.*);

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;

    import llsa_pkg::*;

    localparam int          MAX_SRV     = MAX_SERVERS_DEF;
    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int unsigned PHASES      = 12;
    localparam int unsigned PHASE_ITEMS = 44;
    localparam int unsigned TAIL_CYCLES = 64;

    typedef struct packed {
        logic [SRV_W-1:0] server;
        logic [SRV_W-1:0] next_srv;
        logic             sat;
    } assignment_t;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic              op;
        logic [JOB_W-1:0]  jt;
        int unsigned       reps;
        bit                chk;
        logic [SRV_W-1:0]  exp_server;
        logic [SRV_W-1:0]  exp_next;
        logic              exp_sat;
        logic [NS_W-1:0]   cfg_val;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [NS_W-1:0]   cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic              cmd;
    logic [JOB_W-1:0]  job_time;
    logic              out_valid;
    logic              out_ready;
    logic [SRV_W-1:0]  assigned_server;
    logic [SRV_W-1:0]  next_server;
    logic              saturated;

    logic              req_chk;
    assignment_t       req_exp;

    logic [LOAD_W-1:0] load_acc [MAX_SRV];
    logic [NS_W-1:0]   active_cfg;
    assignment_t       pending_assignments [$];

    int unsigned sent_count  = 0;
    int unsigned recv_count  = 0;
    int unsigned clear_count = 0;
    int unsigned sat_count   = 0;
    int unsigned cfg_writes  = 0;
    int unsigned err_count   = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left  = 0;
    int unsigned rx_span     = 0;
    int unsigned rx_stall_pct = 0;
    bit          full_speed  = 1'b0;

    stim_row_t dir_rows [24] = '{
        '{ROW_REQ, CMD_JOB,   16'h0000,     1, 1'b1, 5'd1, 5'd1, 1'b0, 5'd0},
        '{ROW_REQ, CMD_JOB,   16'hFFFF,     1, 1'b1, 5'd1, 5'd2, 1'b0, 5'd0},
        '{ROW_REQ, CMD_CLEAR, 16'hFFFF,     1, 1'b1, 5'd0, 5'd1, 1'b0, 5'd0},
        '{ROW_REQ, CMD_JOB,   16'h0001,     1, 1'b1, 5'd1, 5'd2, 1'b0, 5'd0},
        '{ROW_REQ, CMD_JOB,   16'h5A5A,    14, 1'b0, 5'd0, 5'd0, 1'b0, 5'd0},
        '{ROW_REQ, CMD_JOB,   16'hA5A5,     5, 1'b0, 5'd0, 5'd0, 1'b0, 5'd0},
        '{ROW_CFG, CMD_JOB,   16'h0000,     1, 1'b0, 5'd0, 5'd0, 1'b0, 5'd4},
        '{ROW_REQ, CMD_JOB,   16'h0007,     3, 1'b0, 5'd0, 5'd0, 1'b0, 5'd0},
        '{ROW_CFG, CMD_JOB,   16'h0000,     1, 1'b0, 5'd0, 5'd0, 1'b0, 5'd0},
        '{ROW_REQ, CMD_JOB,   16'h8000,     1, 1'b0, 5'd0, 5'd0, 1'b0, 5'd0},
        '{ROW_CFG, CMD_JOB,   16'h0000,     1, 1'b0, 5'd0, 5'd0, 1'b0, 5'd31},
        '{ROW_REQ, CMD_JOB,   16'h1234,     4, 1'b0, 5'd0, 5'd0, 1'b0, 5'd0},
        '{ROW_CFG, CMD_JOB,   16'h0000,     1, 1'b0, 5'd0, 5'd0, 1'b0, 5'd17},
        '{ROW_REQ, CMD_CLEAR, 16'h0F0F,     1, 1'b1, 5'd0, 5'd1, 1'b0, 5'd0},
        '{ROW_CFG, CMD_JOB,   16'h0000,     1, 1'b0, 5'd0, 5'd0, 1'b0, 5'd1},
        '{ROW_REQ, CMD_JOB,   16'hFFFF,    40, 1'b0, 5'd0, 5'd0, 1'b0, 5'd0},
        '{ROW_REQ, CMD_JOB,   16'h0001,     1, 1'b1, 5'd1, 5'd1, 1'b0, 5'd0},
        '{ROW_REQ, CMD_JOB,   16'h0000,     1, 1'b1, 5'd1, 5'd1, 1'b0, 5'd0},
        '{ROW_REQ, CMD_JOB,   16'hFFFF,     1, 1'b1, 5'd1, 5'd1, 1'b0, 5'd0},
        '{ROW_CFG, CMD_JOB,   16'h0000,     1, 1'b0, 5'd0, 5'd0, 1'b0, 5'd2},
        '{ROW_REQ, CMD_JOB,   16'h0009,     1, 1'b1, 5'd2, 5'd2, 1'b0, 5'd0},
        '{ROW_REQ, CMD_JOB,   16'hFFFF,     1, 1'b0, 5'd0, 5'd0, 1'b0, 5'd0},
        '{ROW_REQ, CMD_CLEAR, 16'h0000,     1, 1'b1, 5'd0, 5'd1, 1'b0, 5'd0},
        '{ROW_CFG, CMD_JOB,   16'h0000,     1, 1'b0, 5'd0, 5'd0, 1'b0, 5'd16}
    };

    least_loaded_server_assign_unit u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cmd             (cmd),
        .job_time        (job_time),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .assigned_server (assigned_server),
        .next_server     (next_server),
        .saturated       (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned least_loaded_slot();
        int unsigned n;
        int unsigned best;
        n    = active_cfg;
        best = 0;
        if (n == 0)
            n = 1;
        if (n > MAX_SRV)
            n = MAX_SRV;
        for (int unsigned i = 1; i < n; i++)
            if (load_acc[i] < load_acc[best])
                best = i;
        return best;
    endfunction

    function automatic assignment_t assign_job(input logic op, input logic [JOB_W-1:0] jt);
        assignment_t      r;
        int unsigned      slot;
        logic [LOAD_W:0]  sum;
        r = '0;
        if (op == CMD_CLEAR)
        begin
            foreach (load_acc[i])
                load_acc[i] = '0;
        end
        else
        begin
            slot = least_loaded_slot();
            sum  = {1'b0, load_acc[slot]} + (LOAD_W+1)'(jt);
            if (sum[LOAD_W])
            begin
                load_acc[slot] = LOAD_MAX;
                r.sat          = 1'b1;
            end
            else
            begin
                load_acc[slot] = sum[LOAD_W-1:0];
            end
            r.server = SRV_W'(slot + 1);
        end
        r.next_srv = SRV_W'(least_loaded_slot() + 1);
        return r;
    endfunction

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rx_span == 0)
        begin
            rx_span = $urandom_range(16, 128);
            case ($urandom_range(0, 3))
                0:       rx_stall_pct = 0;
                1:       rx_stall_pct = 25;
                2:       rx_stall_pct = 50;
                default: rx_stall_pct = 85;
            endcase
        end
        rx_span--;
        out_ready <= full_speed || ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        assignment_t got;
        assignment_t want;
        assignment_t model;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = {assigned_server, next_server, saturated};
                recv_count++;
                if (got.sat)
                    sat_count++;
                if (pending_assignments.size() == 0)
                begin
                    $error("Result with no request outstanding: server %0d, next %0d, sat %0d",
                           got.server, got.next_srv, got.sat);
                    err_count++;
                end
                else
                begin
                    want = pending_assignments.pop_front();
                    if (got.server !== want.server)
                    begin
                        $error("assigned_server mismatch: expected %0d, got %0d",
                               want.server, got.server);
                        err_count++;
                    end
                    if (got.next_srv !== want.next_srv)
                    begin
                        $error("next_server mismatch: expected %0d, got %0d",
                               want.next_srv, got.next_srv);
                        err_count++;
                    end
                    if (got.sat !== want.sat)
                    begin
                        $error("saturated mismatch: expected %0d, got %0d", want.sat, got.sat);
                        err_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                active_cfg = cfg_data;
            if (in_valid && in_ready)
            begin
                model = assign_job(cmd, job_time);
                pending_assignments.push_back(req_chk ? req_exp : model);
                if (cmd == CMD_CLEAR)
                    clear_count++;
            end
        end
    end

    task automatic push_request(input logic op, input logic [JOB_W-1:0] jt,
                                input bit chk, input assignment_t exp_res);
        in_valid <= 1'b1;
        cmd      <= op;
        job_time <= jt;
        req_chk  <= chk;
        req_exp  <= exp_res;
        do
            @(posedge clk);
        while (!in_ready);
        sent_count++;
    endtask

    task automatic pace_sender();
        int unsigned gap;
        if (full_speed)
            return;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        gap        = $urandom_range(1, 8);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 6);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (recv_count < sent_count)
            @(posedge clk);
    endtask

    task automatic write_server_count(input logic [NS_W-1:0] value);
        wait_results_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    initial
    begin
        assignment_t      typed;
        logic             op;
        logic [JOB_W-1:0] jt;
        logic [NS_W-1:0]  nsv;
        foreach (load_acc[i])
            load_acc[i] = '0;
        active_cfg = NUM_SERVERS_RST;
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        cmd       <= CMD_CLEAR;
        job_time  <= '0;
        req_chk   <= 1'b0;
        req_exp   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            if (dir_rows[r].kind == ROW_CFG)
            begin
                write_server_count(dir_rows[r].cfg_val);
            end
            else
            begin
                typed      = {dir_rows[r].exp_server, dir_rows[r].exp_next, dir_rows[r].exp_sat};
                full_speed = (dir_rows[r].reps > 20);
                for (int unsigned k = 0; k < dir_rows[r].reps; k++)
                begin
                    push_request(dir_rows[r].op, dir_rows[r].jt, dir_rows[r].chk, typed);
                    pace_sender();
                end
                full_speed = 1'b0;
            end
        end

        for (int unsigned ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       nsv = NS_W'(1);
                1:       nsv = NS_W'(MAX_SRV);
                2:       nsv = '0;
                3:       nsv = '1;
                default: nsv = NS_W'($urandom_range(0, 31));
            endcase
            write_server_count(nsv);
            if ($urandom_range(0, 1) == 0)
            begin
                push_request(CMD_CLEAR, JOB_W'($urandom), 1'b0, '0);
                pace_sender();
            end
            for (int unsigned k = 0; k < PHASE_ITEMS; k++)
            begin
                op = ($urandom_range(0, 15) == 0) ? CMD_CLEAR : CMD_JOB;
                case ($urandom_range(0, 3))
                    0:       jt = JOB_W'($urandom_range(0, 15));
                    1:       jt = JOB_W'($urandom_range(16'hFF00, 16'hFFFF));
                    default: jt = JOB_W'($urandom);
                endcase
                push_request(op, jt, 1'b0, '0);
                if ($urandom_range(0, 49) == 0)
                    wait_results_drained();
                else
                    pace_sender();
            end
        end

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_assignments.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_assignments.size());
            err_count++;
        end

        $display("Run covered %0d requests, %0d of them clears, and %0d saturated loads.",
                 sent_count, clear_count, sat_count);
        $display("The server count was rewritten %0d times, zero and the full 5-bit range included.",
                 cfg_writes);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
